// File: rtl/sha1md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_chain;

    localparam t_word IV_H0 = 32'h67452301;
    localparam t_word IV_H1 = 32'hefcdab89;
    localparam t_word IV_H2 = 32'h98badcfe;
    localparam t_word IV_H3 = 32'h10325476;
    localparam t_word IV_H4 = 32'hc3d2e1f0;

    localparam t_chain CHAIN_IV = {IV_H4, IV_H3, IV_H2, IV_H1, IV_H0};

    localparam t_word K_R0 = 32'h5a827999;
    localparam t_word K_R1 = 32'h6ed9eba1;
    localparam t_word K_R2 = 32'h8f1bbcdc;
    localparam t_word K_R3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] ROUND_F1   = 7'd20;
    localparam logic [6:0] ROUND_F2   = 7'd40;
    localparam logic [6:0] ROUND_F3   = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    // Last byte position of a block, and first position that no longer leaves
    // room for the length words.
    localparam logic [5:0] POS_BLOCK_END = 6'd63;
    localparam logic [5:0] POS_LEN_START = 6'd56;

    typedef struct packed {
        logic        start;
        logic        init_chain;
        logic        wr_byte;
        logic [5:0]  byte_pos;
        logic [7:0]  byte_val;
        logic        wr_len;
        logic [63:0] len_bits;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

endpackage

`default_nettype wire

// File: rtl/sha1_message_digest_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Beat
// input     in         i_valid / o_stall  i_data_byte, i_has_data, i_last_item
// output    out        o_valid / i_stall  o_digest_word, o_digest_last
//
// A byte beat that fills a 64-byte block starts a compression: the
// shared round unit runs one SHA-1 round a cycle and then folds into the chain.
// A last beat adds a padding step, a length step and one or two compressions,
// then five digest beats. Synchronous reset restores the IV and count.
// o_stall stays high from a block-completing beat until its compression ends,
// and from a last beat until the final digest beat is taken.

module sha1_message_digest_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_has_data,
    input  wire         i_last_item,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    import sha1md_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BLK   = 3'd1;
    localparam logic [2:0] ST_PAD   = 3'd2;
    localparam logic [2:0] ST_EXTRA = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [2:0] IDX_LAST = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [60:0] r_cnt, n_cnt;
    logic        r_last, n_last;
    logic [2:0]  r_idx, n_idx;

    t_core_ctl   core_ctl;
    t_core_sts   core_sts;
    t_chain      chain;
    logic        in_beat;

    sha1md_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_sts   (core_sts),
        .o_chain (chain)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign in_beat = i_valid && !o_stall;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_idx    = r_idx;
        core_ctl = '0;
        core_ctl.byte_pos = r_cnt[5:0];
        core_ctl.len_bits = {r_cnt, 3'b000};
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_last = i_last_item;
                    if (i_has_data) begin
                        core_ctl.wr_byte  = 1'b1;
                        core_ctl.byte_val = i_data_byte;
                        n_cnt = r_cnt + 61'd1;
                        if (r_cnt[5:0] == POS_BLOCK_END) begin
                            core_ctl.start = 1'b1;
                            n_state = ST_BLK;
                        end else if (i_last_item) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_last_item) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_BLK: begin
                if (core_sts.done) begin
                    n_state = r_last ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                core_ctl.wr_byte  = 1'b1;
                core_ctl.byte_val = PAD_BYTE;
                if (r_cnt[5:0] >= POS_LEN_START) begin
                    core_ctl.start = 1'b1;
                    n_state = ST_EXTRA;
                end else begin
                    n_state = ST_LEN;
                end
            end
            ST_EXTRA: begin
                if (core_sts.done) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                core_ctl.wr_len = 1'b1;
                core_ctl.start  = 1'b1;
                n_state = ST_FINAL;
            end
            ST_FINAL: begin
                if (core_sts.done) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    if (r_idx == IDX_LAST) begin
                        // drop back to the initial vector for the next message
                        core_ctl.init_chain = 1'b1;
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_idx   <= n_idx;
        end
    end

    assign o_valid       = (r_state == ST_OUT);
    assign o_digest_word = chain[r_idx];
    assign o_digest_last = (r_idx == IDX_LAST);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_ctl.start |-> !core_sts.busy)
        else $error("round unit started while busy");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |-> !core_sts.busy)
        else $error("input beat taken during compression");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_digest_last) |=> (r_cnt == '0 && r_state == ST_IDLE))
        else $error("byte count not cleared after digest");

    a_digest_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !core_sts.busy)
        else $error("digest shown while chain still updating");

endmodule

`default_nettype wire

// File: rtl/sha1md_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sha1md_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire sha1md_pkg::t_core_ctl i_ctl,
    output sha1md_pkg::t_core_sts o_sts,
    output sha1md_pkg::t_chain   o_chain
);
    import sha1md_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;

    logic [1:0] r_phase;
    logic [6:0] r_round;
    t_chain     r_chain;
    t_word      r_w [16];
    t_word      r_v [5];

    logic [1:0] lane;
    t_word      f_val;
    t_word      k_val;
    t_word      w_next;
    t_word      tmp;

    assign lane   = ~i_ctl.byte_pos[1:0];
    assign w_next = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    always_comb begin
        if (r_round < ROUND_F1) begin
            f_val = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k_val = K_R0;
        end else if (r_round < ROUND_F2) begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_R1;
        end else if (r_round < ROUND_F3) begin
            f_val = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k_val = K_R2;
        end else begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_R3;
        end
    end

    assign tmp = {r_v[0][26:0], r_v[0][31:27]} + f_val + r_v[4] + k_val + r_w[0];

    // Sequencer: one round per cycle, then fold into the chain value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_round <= '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_ctl.start) begin
                        r_phase <= PH_RUN;
                        r_round <= '0;
                    end
                end
                PH_RUN: begin
                    if (r_round == ROUND_LAST) begin
                        r_phase <= PH_FIN;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                PH_FIN: begin
                    r_phase <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_v[i] <= '0;
            end
        end else if (i_ctl.start && r_phase == PH_IDLE) begin
            for (int i = 0; i < 5; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (r_phase == PH_RUN) begin
            r_v[4] <= r_v[3];
            r_v[3] <= r_v[2];
            r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
            r_v[1] <= r_v[0];
            r_v[0] <= tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= CHAIN_IV;
        end else if (i_ctl.init_chain) begin
            r_chain <= CHAIN_IV;
        end else if (r_phase == PH_FIN) begin
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    // Schedule window: r_w[0] is the word of the current round.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= '0;
            end
        end else if (r_phase == PH_FIN) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= '0;
            end
        end else if (r_phase == PH_RUN) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= {w_next[30:0], w_next[31]};
        end else begin
            if (i_ctl.wr_byte) begin
                r_w[i_ctl.byte_pos[5:2]][{lane, 3'b000} +: 8] <= i_ctl.byte_val;
            end
            if (i_ctl.wr_len) begin
                r_w[14] <= i_ctl.len_bits[63:32];
                r_w[15] <= i_ctl.len_bits[31:0];
            end
        end
    end

    assign o_sts.busy = (r_phase != PH_IDLE);
    assign o_sts.done = (r_phase == PH_FIN);
    assign o_chain    = r_chain;

endmodule

`default_nettype wire
